// File: rtl/core/bfc_pkg.sv
// Shared types and constants of the beacon frequency classifier.
// Used by bfc_datapath, bfc_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

    // Field widths
    localparam int unsigned CAP_W      = 16;
    localparam int unsigned EXT_W      = 32;
    localparam int unsigned FREQ_W     = 26;
    localparam int unsigned TGT_W      = 16;
    localparam int unsigned BEACON_W   = 3;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 26;
    localparam int unsigned CNT_W      = $clog2(FREQ_W);

    // Packed stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [CAP_W-1:0] HALF_RANGE = 16'h8000;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_CAPTURE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OVERFLOW = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT  = 2'd2;

    // Beacon codes
    localparam logic [BEACON_W-1:0] BEACON_NOMATCH = 3'd4;
    localparam logic [IDX_W-1:0]    TARGET_G       = 2'd0;
    localparam logic [IDX_W-1:0]    TARGET_B       = 2'd1;
    localparam logic [IDX_W-1:0]    TARGET_R       = 2'd2;
    localparam logic [IDX_W-1:0]    TARGET_L       = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_RATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_G  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_B  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_R  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_L  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 3'd5;

    // Register reset values
    localparam logic [FREQ_W-1:0] RST_TICK_RATE = 26'd2500000;
    localparam logic [TGT_W-1:0]  RST_TARGET_G  = 16'd3333;
    localparam logic [TGT_W-1:0]  RST_TARGET_B  = 16'd1427;
    localparam logic [TGT_W-1:0]  RST_TARGET_R  = 16'd2000;
    localparam logic [TGT_W-1:0]  RST_TARGET_L  = 16'd2000;
    localparam logic [TGT_W-1:0]  RST_TOLERANCE = 16'd30;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             div_step;
        logic             div_last;
        logic             cls_check;
        logic [IDX_W-1:0] cls_idx;
        logic             load_out;
    } bfc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_start;
        logic match;
        logic out_free;
    } bfc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/beacon_frequency_classifier.sv
// Top level of the beacon frequency classifier: joins controller and datapath.
// Depends on bfc_pkg, bfc_ctrl and bfc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input beats (s_*): s_tuser carries the request kind (capture edge, timer
//   overflow tick, alignment timeout); s_tdata carries the 16-bit capture
//   value and the pending overflow flag. Result beats (m_*): m_tdata packs
//   the beacon code and frequency, m_tuser flags a timeout report.
//   Registers are written through cfg_we / cfg_addr / cfg_wdata, one per
//   cycle; the user must write them only while the block is idle, which the block does not enforce.
// Sequencing
//   Overflow ticks and captures that need no division stay in the idle state.
//   A timeout goes through the emit step into the output register.
//   A capture that is measured runs the restoring divider (one quotient bit
//   a cycle), then checks up to four targets, one a cycle, and loads a
//   report through the emit step only if a target matches.
//   s_tready is high only in the idle state, so one item is taken at a time.
// Reset: aresetn (synchronous, active low) restores the register defaults,
//   clears the rollover count, previous capture, alignment and the output.
// Stalls
//   A report waits in the output register while m_tready is low; the block
//   keeps taking beats that produce no report, and a beat that does produce
//   one holds in the emit step until the output register frees up.
module beacon_frequency_classifier (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [bfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bfc_pkg::S_TDATA_W-1:0]      s_tdata,  // [15:0] capture_time, [16] overflow_pending
    input  wire logic [bfc_pkg::REQ_W-1:0]          s_tuser,  // [1:0] req_type
    // Result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [bfc_pkg::M_TDATA_W-1:0]           m_tdata,  // [2:0] beacon, [28:3] frequency
    output logic                                    m_tuser   // [0] from_timeout
);

    bfc_pkg::bfc_cmd_t    cmd;
    bfc_pkg::bfc_status_t status;

    bfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: rtl/core/bfc_datapath.sv
// Datapath of the beacon frequency classifier: registers, timestamp extension,
// restoring divider, tolerance check and output register. Depends on bfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfc_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [bfc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [bfc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic [bfc_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic [bfc_pkg::REQ_W-1:0]           s_tuser,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [bfc_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                     m_tuser,
    input  wire bfc_pkg::bfc_cmd_t                   cmd,
    output bfc_pkg::bfc_status_t                     status
);

    localparam int unsigned FW = bfc_pkg::FREQ_W;
    localparam int unsigned EW = bfc_pkg::EXT_W;
    localparam int unsigned CW = bfc_pkg::CAP_W;
    localparam int unsigned TW = bfc_pkg::TGT_W;

    // Configuration
    logic [FW-1:0] tick_rate_reg;
    logic [TW-1:0] target_g_reg;
    logic [TW-1:0] target_b_reg;
    logic [TW-1:0] target_r_reg;
    logic [TW-1:0] target_l_reg;
    logic [TW-1:0] tolerance_reg;

    // Measurement state
    logic [CW-1:0]                   roll_reg;
    logic [EW-1:0]                   prev_reg;
    logic                            aligned_reg;
    logic [bfc_pkg::BEACON_W-1:0]    latched_reg;
    logic [FW-1:0]                   last_freq_reg;
    logic                            tmo_reg;

    // Divider
    logic [EW-1:0] divisor_reg;
    logic [EW-1:0] rem_reg;
    logic [FW-1:0] dvd_reg;

    // Output register
    logic                            out_valid_reg;
    logic [bfc_pkg::BEACON_W-1:0]    out_beacon_reg;
    logic [FW-1:0]                   out_freq_reg;
    logic                            out_tmo_reg;

    logic [CW-1:0]   cap;
    logic            pend;
    logic            roll_bump;
    logic [CW-1:0]   roll_inc;
    logic [CW-1:0]   roll_cur;
    logic [EW-1:0]   current;
    logic [EW-1:0]   period;
    logic [EW+1:0]   trial;
    logic            qbit;
    logic [EW-1:0]   rem_next;
    logic [FW-1:0]   dvd_next;
    logic [TW-1:0]   tgt;
    logic [FW-1:0]   tgt_ext;
    logic [FW-1:0]   diff;
    logic            out_free;

    assign cap       = s_tdata[CW-1:0];
    assign pend      = s_tdata[CW];
    assign roll_inc  = roll_reg + CW'(1);
    assign roll_bump = pend && (cap < bfc_pkg::HALF_RANGE);
    assign roll_cur  = roll_bump ? roll_inc : roll_reg;
    assign current   = {roll_cur, cap};
    assign period    = current - prev_reg;

    // One restoring step: one quotient bit a cycle, MSB first
    assign trial    = {1'b0, rem_reg, dvd_reg[FW-1]} - {2'b00, divisor_reg};
    assign qbit     = ~trial[EW+1];
    assign rem_next = qbit ? trial[EW-1:0] : {rem_reg[EW-2:0], dvd_reg[FW-1]};
    assign dvd_next = {dvd_reg[FW-2:0], qbit};

    // Tolerance check against one target a cycle
    always_comb begin
        case (cmd.cls_idx)
            bfc_pkg::TARGET_G: tgt = target_g_reg;
            bfc_pkg::TARGET_B: tgt = target_b_reg;
            bfc_pkg::TARGET_R: tgt = target_r_reg;
            bfc_pkg::TARGET_L: tgt = target_l_reg;
            default:           tgt = target_g_reg;
        endcase
    end

    assign tgt_ext = FW'(tgt);
    assign diff    = (last_freq_reg >= tgt_ext) ? (last_freq_reg - tgt_ext)
                                                : (tgt_ext - last_freq_reg);
    assign out_free = ~out_valid_reg | m_tready;

    assign status.div_start = (period != '0) && !aligned_reg;
    assign status.match     = diff <= FW'(tolerance_reg);
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= bfc_pkg::RST_TICK_RATE;
            target_g_reg  <= bfc_pkg::RST_TARGET_G;
            target_b_reg  <= bfc_pkg::RST_TARGET_B;
            target_r_reg  <= bfc_pkg::RST_TARGET_R;
            target_l_reg  <= bfc_pkg::RST_TARGET_L;
            tolerance_reg <= bfc_pkg::RST_TOLERANCE;
        end else if (cfg_we) begin
            case (cfg_addr)
                bfc_pkg::REG_TICK_RATE: tick_rate_reg <= cfg_wdata;
                bfc_pkg::REG_TARGET_G:  target_g_reg  <= cfg_wdata[TW-1:0];
                bfc_pkg::REG_TARGET_B:  target_b_reg  <= cfg_wdata[TW-1:0];
                bfc_pkg::REG_TARGET_R:  target_r_reg  <= cfg_wdata[TW-1:0];
                bfc_pkg::REG_TARGET_L:  target_l_reg  <= cfg_wdata[TW-1:0];
                bfc_pkg::REG_TOLERANCE: tolerance_reg <= cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_reg      <= '0;
            prev_reg      <= '0;
            aligned_reg   <= 1'b0;
            latched_reg   <= '0;
            last_freq_reg <= '0;
            tmo_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                tmo_reg <= (s_tuser == bfc_pkg::REQ_TIMEOUT);
                case (s_tuser)
                    bfc_pkg::REQ_OVERFLOW: roll_reg <= roll_inc;
                    bfc_pkg::REQ_CAPTURE: begin
                        roll_reg <= roll_cur;
                        prev_reg <= current;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_last) begin
                last_freq_reg <= dvd_next;
            end
            if (cmd.cls_check && status.match) begin
                aligned_reg <= 1'b1;
                latched_reg <= bfc_pkg::BEACON_W'(cmd.cls_idx);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider and output payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            divisor_reg <= period;
            rem_reg     <= '0;
            dvd_reg     <= tick_rate_reg;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
        if (cmd.load_out) begin
            out_beacon_reg <= aligned_reg ? latched_reg : bfc_pkg::BEACON_NOMATCH;
            out_freq_reg   <= last_freq_reg;
            out_tmo_reg    <= tmo_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bfc_pkg::M_TDATA_W'({out_freq_reg, out_beacon_reg});
    assign m_tuser  = out_tmo_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("output register not valid after load");

    a_overflow_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_tuser == bfc_pkg::REQ_OVERFLOW)
        |=> (roll_reg == CW'($past(roll_reg) + CW'(1))))
        else $error("rollover count did not advance on overflow tick");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bfc_ctrl.sv
// Controller of the beacon frequency classifier: accept, divide, classify
// and emit sequencing. Depends on bfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfc_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic [bfc_pkg::REQ_W-1:0]     s_tuser,
    output logic                               s_tready,
    input  wire bfc_pkg::bfc_status_t          status,
    output bfc_pkg::bfc_cmd_t                  cmd
);

    localparam int unsigned CNW = bfc_pkg::CNT_W;
    localparam logic [CNW-1:0] DIV_LAST = CNW'(bfc_pkg::FREQ_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DIVIDE   = 4'b0010,
        ST_CLASSIFY = 4'b0100,
        ST_EMIT     = 4'b1000
    } bfc_state_t;

    bfc_state_t                    state_reg, state_next;
    logic [CNW-1:0]                cnt_reg, cnt_next;
    logic [bfc_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.cls_idx   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == bfc_pkg::REQ_CAPTURE && status.div_start) begin
                        state_next = ST_DIVIDE;
                        cnt_next   = '0;
                    end else if (s_tuser == bfc_pkg::REQ_TIMEOUT) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_CLASSIFY;
                    idx_next     = bfc_pkg::TARGET_G;
                end else begin
                    cnt_next = cnt_reg + CNW'(1);
                end
            end
            ST_CLASSIFY: begin
                // Targets in priority order G, B, R, L; first match wins
                cmd.cls_check = 1'b1;
                if (status.match) begin
                    state_next = ST_EMIT;
                end else if (idx_reg == bfc_pkg::TARGET_L) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + bfc_pkg::IDX_W'(1);
                end
            end
            ST_EMIT: begin
                // Hold until the output register can take the report
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("output loaded while still occupied");

    a_divide_to_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && cnt_reg == DIV_LAST)
        |=> (state_reg == ST_CLASSIFY && idx_reg == bfc_pkg::TARGET_G))
        else $error("classification did not start after last divide step");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (cnt_reg <= DIV_LAST))
        else $error("divide step count out of range");
`endif

endmodule

`default_nettype wire

// File: test/tb_beacon_frequency_classifier.sv
// Self-checking testbench for beacon_frequency_classifier: a clocked driver feeds
// queued request beats, a predictor computes the expected reports, a monitor checks them.
// Depends on bfc_pkg and the RTL of the classifier; nothing else.
`timescale 1ns / 1ps

module tb_beacon_frequency_classifier;

    localparam int unsigned REQ_W      = bfc_pkg::REQ_W;
    localparam int unsigned CAP_W      = bfc_pkg::CAP_W;
    localparam int unsigned EXT_W      = bfc_pkg::EXT_W;
    localparam int unsigned FREQ_W     = bfc_pkg::FREQ_W;
    localparam int unsigned TGT_W      = bfc_pkg::TGT_W;
    localparam int unsigned BEACON_W   = bfc_pkg::BEACON_W;
    localparam int unsigned CFG_ADDR_W = bfc_pkg::CFG_ADDR_W;
    localparam int unsigned CFG_DATA_W = bfc_pkg::CFG_DATA_W;
    localparam int unsigned S_TDATA_W  = bfc_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W  = bfc_pkg::M_TDATA_W;

    // Request kind 3 has no meaning; the block must drop it.
    localparam logic [REQ_W-1:0]      REQ_UNUSED   = 2'd3;
    // Register indexes beyond the map; writes there must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7  = 3'd7;
    localparam int                    DRAIN_CYCLES = 40;
    localparam int                    HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [CAP_W-1:0] cap;
        logic             pend;
    } beat_t;

    typedef struct packed {
        logic [BEACON_W-1:0] beacon;
        logic [FREQ_W-1:0]   freq;
        logic                from_tmo;
    } report_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] capture_time, [16] overflow_pending
    logic [REQ_W-1:0]      s_tuser   = '0;   // [1:0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [2:0] beacon, [28:3] frequency
    logic                  m_tuser;          // [0] from_timeout

    beacon_frequency_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and measurement state.
    // ------------------------------------------------------------------
    bit [FREQ_W-1:0]   rate_reg  = bfc_pkg::RST_TICK_RATE;
    bit [TGT_W-1:0]    tgt_hz [4] = '{bfc_pkg::RST_TARGET_G, bfc_pkg::RST_TARGET_B,
                                      bfc_pkg::RST_TARGET_R, bfc_pkg::RST_TARGET_L};
    bit [TGT_W-1:0]    tol_reg   = bfc_pkg::RST_TOLERANCE;
    bit [CAP_W-1:0]    rollover_cnt = '0;
    bit [EXT_W-1:0]    prev_stamp   = '0;
    bit                aligned      = 1'b0;
    bit [BEACON_W-1:0] latched      = '0;
    bit [FREQ_W-1:0]   last_freq    = '0;

    beat_t   request_q[$];   // beats waiting to be offered
    report_t report_q[$];    // reports the block still owes us
    int      error_count = 0;

    // Stimulus shaping knobs, changed only between phases.
    bit          idle_on       = 1'b1;
    bit          tight_periods = 1'b0;
    bit [31:0]   timer_pos     = '0;

    function automatic bit near_target(bit [31:0] f, bit [TGT_W-1:0] t);
        bit [31:0] d;
        d = (f >= t) ? f - t : t - f;
        return d <= tol_reg;
    endfunction

    // Advance the shadow by one accepted beat and queue any report it owes.
    task automatic measure_beat(input beat_t b);
        bit [EXT_W-1:0]    stamp;
        bit [EXT_W-1:0]    period;
        bit [31:0]         quo;
        bit [BEACON_W-1:0] code;
        case (b.req)
            bfc_pkg::REQ_OVERFLOW: begin
                rollover_cnt++;
            end
            bfc_pkg::REQ_TIMEOUT: begin
                report_q.push_back('{aligned ? latched : bfc_pkg::BEACON_NOMATCH,
                                     last_freq, 1'b1});
            end
            bfc_pkg::REQ_CAPTURE: begin
                // A pending rollover below half range belongs to this capture.
                if (b.pend && b.cap < bfc_pkg::HALF_RANGE) rollover_cnt++;
                stamp  = {rollover_cnt, b.cap};
                period = stamp - prev_stamp;
                if (period != 0 && !aligned) begin
                    quo       = {{(32 - FREQ_W){1'b0}}, rate_reg} / period;
                    last_freq = quo[FREQ_W-1:0];
                    code      = bfc_pkg::BEACON_NOMATCH;
                    // Targets in priority order G, B, R, L.
                    for (int i = 0; i < 4; i++) begin
                        if (code == bfc_pkg::BEACON_NOMATCH && near_target(quo, tgt_hz[i]))
                            code = BEACON_W'(i);
                    end
                    if (code != bfc_pkg::BEACON_NOMATCH) begin
                        latched = code;
                        aligned = 1'b1;
                        report_q.push_back('{code, last_freq, 1'b0});
                    end
                end
                prev_stamp = stamp;
            end
            default: ;
        endcase
    endtask

    // Most gaps short, a few long; none at all while idling is off.
    function automatic int gap_len();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued beats, predict each one as it is accepted.
    // ------------------------------------------------------------------
    beat_t cur_beat = '0;
    bit    offering;
    int    send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                measure_beat(cur_beat);
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0) begin
                    cur_beat = request_q.pop_front();
                    send_gap = gap_len();
                    offering = 1'b1;
                end
            end
            // One assignment per step keeps back-to-back beats glitch free.
            s_tvalid <= offering;
            s_tdata  <= {{(S_TDATA_W - CAP_W - 1){1'b0}}, cur_beat.pend, cur_beat.cap};
            s_tuser  <= cur_beat.req;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each report beat and drive back-pressure.
    // ------------------------------------------------------------------
    report_t want;
    int      reports_seen = 0;
    int      hold_left    = 0;
    int      stall_left   = 0;
    bit      ready_nxt;

    task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
        error_count++;
        $display("%0t %s: expected %0d, got %0d", $time, what, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    note_mismatch("report with nothing outstanding, beacon", -1, m_tdata[2:0]);
                end else begin
                    want = report_q.pop_front();
                    if (m_tdata[2:0] !== want.beacon)
                        note_mismatch("beacon", want.beacon, m_tdata[2:0]);
                    if (m_tdata[28:3] !== want.freq)
                        note_mismatch("frequency", want.freq, m_tdata[28:3]);
                    if (m_tuser !== want.from_tmo)
                        note_mismatch("from_timeout", want.from_tmo, m_tuser);
                end
                reports_seen++;
                // Hold off for a long stretch so the block backs up its input.
                if (reports_seen == 25 || reports_seen == 160) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                    ready_nxt  = (stall_left == 0);
                end
            end
            m_tready <= ready_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_beat(input logic [REQ_W-1:0] req, input logic [CAP_W-1:0] cap,
                            input logic pend);
        request_q.push_back('{req, cap, pend});
    endtask

    function automatic int pick_period();
        int r;
        if (tight_periods && $urandom_range(0, 9) < 7) return $urandom_range(480, 520);
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 3000);
        if (r < 9) return $urandom_range(3001, 70000);
        return $urandom_range(70001, 300000);
    endfunction

    // One beacon edge on a free-running timer: overflow ticks for each wrap,
    // the last wrap sometimes left pending and carried by the capture instead.
    task automatic add_edge();
        bit [31:0]    nxt;
        bit [CAP_W-1:0] wraps;
        bit           pend;
        nxt   = timer_pos + pick_period();
        wraps = nxt[31:16] - timer_pos[31:16];
        pend  = (wraps != 0) && (nxt[15:0] < bfc_pkg::HALF_RANGE)
                && ($urandom_range(0, 2) == 0);
        for (int k = 0; k < int'(wraps) - int'(pend); k++)
            add_beat(bfc_pkg::REQ_OVERFLOW, CAP_W'($urandom), 1'($urandom_range(0, 1)));
        // A stale flag above half range must be ignored.
        if (!pend && nxt[15:0] >= bfc_pkg::HALF_RANGE && $urandom_range(0, 7) == 0)
            pend = 1'b1;
        add_beat(bfc_pkg::REQ_CAPTURE, nxt[15:0], pend);
        timer_pos = nxt;
    endtask

    // Mostly well-formed pulse trains, with timeouts and some noise.
    task automatic add_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                add_beat(bfc_pkg::REQ_TIMEOUT, CAP_W'($urandom), 1'($urandom_range(0, 1)));
            else if (r < 22)
                add_beat(REQ_W'($urandom_range(0, 3)), CAP_W'($urandom),
                         1'($urandom_range(0, 1)));
            else
                add_edge();
        end
    endtask

    // Wait until every beat is taken and every report is back, then let any
    // capture that owes nothing finish its divide.
    task automatic settle();
        while (request_q.size() != 0 || s_tvalid || report_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            bfc_pkg::REG_TICK_RATE: rate_reg = val;
            bfc_pkg::REG_TARGET_G:  tgt_hz[bfc_pkg::TARGET_G] = val[TGT_W-1:0];
            bfc_pkg::REG_TARGET_B:  tgt_hz[bfc_pkg::TARGET_B] = val[TGT_W-1:0];
            bfc_pkg::REG_TARGET_R:  tgt_hz[bfc_pkg::TARGET_R] = val[TGT_W-1:0];
            bfc_pkg::REG_TARGET_L:  tgt_hz[bfc_pkg::TARGET_L] = val[TGT_W-1:0];
            bfc_pkg::REG_TOLERANCE: tol_reg = val[TGT_W-1:0];
            default: ;
        endcase
    endtask

    // Write the whole map, with junk in the upper bits of the narrow registers.
    task automatic program_regs(input logic [FREQ_W-1:0] rate, input logic [TGT_W-1:0] g,
                                input logic [TGT_W-1:0] b, input logic [TGT_W-1:0] r,
                                input logic [TGT_W-1:0] l, input logic [TGT_W-1:0] tol);
        logic [CFG_DATA_W-TGT_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? '1 : (CFG_DATA_W - TGT_W)'($urandom);
        write_reg(bfc_pkg::REG_TICK_RATE, rate);
        write_reg(bfc_pkg::REG_TARGET_G, {junk, g});
        write_reg(bfc_pkg::REG_TARGET_B, {junk, b});
        write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
        write_reg(bfc_pkg::REG_TARGET_R, {junk, r});
        write_reg(bfc_pkg::REG_TARGET_L, {junk, l});
        write_reg(REG_SPARE_7, '1);
        write_reg(bfc_pkg::REG_TOLERANCE, {junk, tol});
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed beats on reset defaults; no period lands near a default target.
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'h0000, 1'b0);   // not aligned: unknown, zero
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h0000, 1'b0);   // zero period: skip the divide
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h0064, 1'b0);
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'hFFFF, 1'b1);
        add_beat(bfc_pkg::REQ_OVERFLOW, 16'hFFFF, 1'b1);   // data fields ignored on a tick
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h7FFF, 1'b1);   // pending rollover counted here
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h8000, 1'b1);   // flag ignored, period of one tick
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'h0000, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE,  16'hFFFF, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE,  16'hFFFF, 1'b1);   // flag ignored, zero period
        add_beat(REQ_UNUSED,            16'h0001, 1'b1);   // dropped with no state change
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h0000, 1'b0);   // timestamp goes backward
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'h5A5A, 1'b0);
        add_beat(bfc_pkg::REQ_OVERFLOW, 16'h0000, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h0001, 1'b1);
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'hA5A5, 1'b1);
        add_beat(REQ_UNUSED,            16'hFFFF, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE,  16'h8001, 1'b0);
        add_beat(bfc_pkg::REQ_TIMEOUT,  16'h0000, 1'b0);
        settle();

        // Fastest tick rate; targets no integer period can hit exactly.
        program_regs(26'h3FFFFFF, 16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd0);
        add_random(300);
        settle();

        // Zero tick rate: every quotient is zero, targets all above it. No idling here.
        idle_on = 1'b0;
        program_regs(26'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0);
        add_random(200);
        settle();

        // A run of overflow ticks between captures, back to back.
        program_regs(26'd1000, 16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd0);
        add_beat(bfc_pkg::REQ_CAPTURE, 16'h1000, 1'b0);
        for (int k = 0; k < 6; k++) add_beat(bfc_pkg::REQ_OVERFLOW, 16'h0000, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE, 16'h0800, 1'b0);
        add_beat(bfc_pkg::REQ_TIMEOUT, 16'h0000, 1'b0);
        add_beat(bfc_pkg::REQ_OVERFLOW, 16'h0000, 1'b0);
        add_beat(bfc_pkg::REQ_CAPTURE, 16'h0900, 1'b0);
        add_beat(bfc_pkg::REQ_TIMEOUT, 16'h0000, 1'b0);
        settle();

        // Tick rate below the targets, so nothing can match yet.
        idle_on = 1'b1;
        program_regs(FREQ_W'($urandom_range(1, 65534)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'd0);
        add_random(350);
        settle();

        // R and L share a target; periods near 500 ticks should lock onto R.
        tight_periods = 1'b1;
        program_regs(26'd2500000, 16'd100, 16'd200, 16'd5000, 16'd5000, 16'd40);
        add_random(400);
        settle();
        tight_periods = 1'b0;

        // Once aligned, register extremes must not change what is reported.
        program_regs(26'h3FFFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        add_random(230);
        settle();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bfc_pkg.sv
rtl/core/bfc_datapath.sv
rtl/core/bfc_ctrl.sv
rtl/core/beacon_frequency_classifier.sv
test/tb_beacon_frequency_classifier.sv
